// ===== rtl/core/bxds_pkg.sv =====
// ----------------------------------------------------------------------------
// bxds_pkg: shared definitions for the box average downscaler
// Register codes, field widths, reset values and the types that the front end
// and the divider back end pass to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bxds_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_RATIO_DEF = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_W     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_H     = 2'd2;

    // Register widths and reset values.
    localparam int IMAGE_WIDTH_W = 11;
    localparam int BLOCK_W       = 5;

    localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST = 11'd640;
    localparam logic [BLOCK_W-1:0]       BLOCK_W_RST     = 5'd2;
    localparam logic [BLOCK_W-1:0]       BLOCK_H_RST     = 5'd2;

    // Pixel width.
    localparam int PIX_W = 8;

    // Depth of the queue between the front end and the divider.
    localparam int QUEUE_DEPTH = 4;

    // Frame tags kept with each column sum. Tag zero marks a cleared entry.
    localparam int                 EPOCH_W     = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = 4'd0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'hF;

    // One finished output item.
    typedef struct packed {
        logic             row_end;
        logic [PIX_W-1:0] mean;
    } result_t;

    // Front-end status seen by the top level.
    typedef struct packed {
        logic clearing;
        logic pushing;
    } front_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bxds_queue.sv =====
// ----------------------------------------------------------------------------
// bxds_queue: short FIFO between front end and divider
// Holds finished tile sums with their divisor and row-end flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bxds_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = bxds_pkg::QUEUE_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic                            not_empty,
    output logic [WIDTH-1:0]                head_data,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];
    assign level     = count_reg;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + LVL_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bxds_front.sv =====
// ----------------------------------------------------------------------------
// bxds_front: pixel intake and column-sum update
// Tracks the raster position, accumulates tile rows and updates the
// per-tile-column sums in a tagged line store. Finished tiles go to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bxds_front #(
    parameter int MAX_WIDTH = bxds_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RATIO = bxds_pkg::MAX_RATIO_DEF,
    parameter int QDEPTH    = bxds_pkg::QUEUE_DEPTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Pixel input
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [bxds_pkg::PIX_W-1:0]             s_pixel,
    input  wire logic                                   s_frame_start,
    // Clamped configuration
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]         cfg_w,
    input  wire logic [$clog2(MAX_RATIO+1)-1:0]         cfg_bw,
    input  wire logic [$clog2(MAX_RATIO+1)-1:0]         cfg_bh,
    input  wire logic [$clog2(MAX_RATIO*MAX_RATIO+1)-1:0] cfg_div,
    input  wire logic                                   cfg_recalc,
    // Queue
    input  wire logic [$clog2(QDEPTH+1)-1:0]            q_level,
    output logic                                        q_push,
    output logic [$clog2(MAX_RATIO*MAX_RATIO*255+1)+$clog2(MAX_RATIO*MAX_RATIO+1):0]
                                                        q_data,
    output bxds_pkg::front_status_t                     status
);

    localparam int WC_W  = $clog2(MAX_WIDTH+1);
    localparam int RC_W  = $clog2(MAX_RATIO+1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int X_W   = AW;
    localparam int TC_W  = $clog2(MAX_WIDTH+1);
    localparam int CT_W  = $clog2(MAX_RATIO);
    localparam int TE_W  = $clog2((MAX_WIDTH+1)*MAX_RATIO+1);
    localparam int TRS_W = $clog2(MAX_RATIO*255+1);
    localparam int CS_W  = $clog2(MAX_RATIO*MAX_RATIO*255+1);
    localparam int DV_W  = $clog2(MAX_RATIO*MAX_RATIO+1);
    localparam int EP_W  = bxds_pkg::EPOCH_W;
    localparam int LV_W  = $clog2(QDEPTH+1);

    // Raster counters.
    logic [X_W-1:0]   x_reg,   x_next;
    logic [CT_W-1:0]  col_reg, col_next;
    logic [CT_W-1:0]  row_reg, row_next;
    logic [TC_W-1:0]  tc_reg,  tc_next;
    logic [TE_W-1:0]  te_reg,  te_next;
    logic [TRS_W-1:0] trs_reg, trs_next;
    logic [EP_W-1:0]  epoch_reg, epoch_next;

    // Clearing pass.
    logic             clr_busy_reg, clr_busy_next;
    logic [AW-1:0]    clr_cnt_reg,  clr_cnt_next;

    // Column-sum update stage.
    logic             b_valid_reg;
    logic [AW-1:0]    b_addr_reg;
    logic             b_load_reg;
    logic             b_emit_reg;
    logic             b_row_end_reg;
    logic [TRS_W-1:0] b_trs_reg;
    logic [EP_W-1:0]  b_epoch_reg;

    // Line store with frame tags, its read register and the bypass.
    logic [EP_W+CS_W-1:0] col_mem [MAX_WIDTH];
    logic [EP_W+CS_W-1:0] rd_reg;
    logic                 fwd_hit_reg;
    logic [CS_W-1:0]      fwd_val_reg;

    // Effective values after a frame start.
    logic             accept;
    logic             wrap_start;
    logic [X_W-1:0]   eff_x;
    logic [CT_W-1:0]  eff_col;
    logic [CT_W-1:0]  eff_row;
    logic [TC_W-1:0]  eff_tc;
    logic [TE_W-1:0]  eff_te;
    logic [TRS_W-1:0] eff_trs;
    logic [EP_W-1:0]  eff_epoch;
    logic [TRS_W-1:0] trs_sum;
    logic             fits;
    logic             complete;
    logic             row_done;
    logic             band_done;
    logic             tile_last;
    logic [AW-1:0]    a_addr;
    logic             room;
    logic [CS_W-1:0]  b_base;
    logic [CS_W-1:0]  b_new;

    // A frame start that would wrap the tag waits for a clearing pass.
    assign wrap_start = s_tvalid && s_frame_start && (epoch_reg == bxds_pkg::EPOCH_LAST);
    assign room = ((LV_W+1)'(q_level) + (LV_W+1)'(b_valid_reg && b_emit_reg))
                  < (LV_W+1)'(QDEPTH);
    assign s_tready = !clr_busy_reg && !cfg_recalc && !wrap_start && room;
    assign accept   = s_tvalid && s_tready;

    // Counters as seen by this pixel.
    always_comb begin
        if (s_frame_start) begin
            eff_x     = '0;
            eff_col   = '0;
            eff_row   = '0;
            eff_tc    = '0;
            eff_te    = TE_W'(cfg_bw);
            eff_trs   = '0;
            eff_epoch = epoch_reg + EP_W'(1);
        end else begin
            eff_x     = x_reg;
            eff_col   = col_reg;
            eff_row   = row_reg;
            eff_tc    = tc_reg;
            eff_te    = te_reg;
            eff_trs   = trs_reg;
            eff_epoch = epoch_reg;
        end
    end

    // Tile classification.
    assign trs_sum   = eff_trs + TRS_W'(s_pixel);
    assign fits      = {1'b0, eff_te} <= (TE_W+1)'(cfg_w);
    assign complete  = fits && ((RC_W'(eff_col) + RC_W'(1)) >= cfg_bw);
    assign row_done  = (WC_W'(eff_x) + WC_W'(1)) >= cfg_w;
    assign band_done = (RC_W'(eff_row) + RC_W'(1)) >= cfg_bh;
    assign tile_last = ({1'b0, eff_te} + (TE_W+1)'(cfg_bw)) > (TE_W+1)'(cfg_w);
    assign a_addr    = eff_tc[AW-1:0];

    // Next counter values.
    always_comb begin
        x_next     = x_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        tc_next    = tc_reg;
        te_next    = te_reg;
        trs_next   = trs_reg;
        epoch_next = epoch_reg;
        if (accept) begin
            epoch_next = eff_epoch;
            col_next   = eff_col;
            tc_next    = eff_tc;
            te_next    = eff_te;
            trs_next   = eff_trs;
            if (complete) begin
                trs_next = '0;
                col_next = '0;
                tc_next  = eff_tc + TC_W'(1);
                te_next  = eff_te + TE_W'(cfg_bw);
            end else if (fits) begin
                trs_next = trs_sum;
                col_next = eff_col + CT_W'(1);
            end
            if (row_done) begin
                x_next   = '0;
                col_next = '0;
                tc_next  = '0;
                te_next  = TE_W'(cfg_bw);
                trs_next = '0;
                row_next = band_done ? '0 : eff_row + CT_W'(1);
            end else begin
                x_next   = eff_x + X_W'(1);
                row_next = eff_row;
            end
        end else if (cfg_recalc || clr_busy_reg) begin
            // Rebuild the tile end after a register write or reset.
            te_next = TE_W'((tc_reg + TC_W'(1)) * cfg_bw);
        end
        if (clr_busy_reg || wrap_start) begin
            epoch_next = bxds_pkg::EPOCH_FIRST;
        end
    end

    // Clearing pass control.
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_WIDTH-1)) begin
                clr_busy_next = 1'b0;
            end
        end else if (wrap_start && !b_valid_reg) begin
            clr_busy_next = 1'b1;
            clr_cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            tc_reg       <= '0;
            te_reg       <= '0;
            trs_reg      <= '0;
            epoch_reg    <= bxds_pkg::EPOCH_FIRST;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            b_valid_reg  <= 1'b0;
        end else begin
            x_reg        <= x_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            tc_reg       <= tc_next;
            te_reg       <= te_next;
            trs_reg      <= trs_next;
            epoch_reg    <= epoch_next;
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
            b_valid_reg  <= accept && complete;
        end
    end

    // Payload of the update stage.
    always_ff @(posedge aclk) begin
        b_addr_reg    <= a_addr;
        b_load_reg    <= (eff_row == '0);
        b_emit_reg    <= band_done;
        b_row_end_reg <= tile_last;
        b_trs_reg     <= trs_sum;
        b_epoch_reg   <= eff_epoch;
        fwd_hit_reg   <= b_valid_reg && (b_addr_reg == a_addr);
        fwd_val_reg   <= b_new;
    end

    // Old sum: bypassed from the last write, or zero if the tag is stale.
    always_comb begin
        if (fwd_hit_reg) begin
            b_base = fwd_val_reg;
        end else if (rd_reg[CS_W +: EP_W] == b_epoch_reg) begin
            b_base = rd_reg[CS_W-1:0];
        end else begin
            b_base = '0;
        end
        b_new = b_load_reg ? CS_W'(b_trs_reg) : b_base + CS_W'(b_trs_reg);
    end

    // Line store: one write port shared by clearing and update, one read.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            col_mem[clr_cnt_reg] <= {bxds_pkg::EPOCH_CLEAR, {CS_W{1'b0}}};
        end else if (b_valid_reg) begin
            col_mem[b_addr_reg] <= {b_epoch_reg, b_new};
        end
        rd_reg <= col_mem[a_addr];
    end

    // Finished tiles go to the queue.
    assign q_push  = b_valid_reg && b_emit_reg;
    assign q_data  = {b_row_end_reg, DV_W'(cfg_div), b_new};

    assign status.clearing = clr_busy_reg;
    assign status.pushing  = q_push;

endmodule

`default_nettype wire

// ===== rtl/core/bxds_divider.sv =====
// ----------------------------------------------------------------------------
// bxds_divider: back end, tile sum to mean
// Restoring divider, one quotient bit per cycle, with an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bxds_divider #(
    parameter int MAX_RATIO = bxds_pkg::MAX_RATIO_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  wire logic [$clog2(MAX_RATIO*MAX_RATIO*255+1)+$clog2(MAX_RATIO*MAX_RATIO+1):0]
                                           q_data,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output bxds_pkg::result_t              m_result
);

    localparam int CS_W  = $clog2(MAX_RATIO*MAX_RATIO*255+1);
    localparam int DV_W  = $clog2(MAX_RATIO*MAX_RATIO+1);
    localparam int CNT_W = $clog2(CS_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [CS_W-1:0]   num_reg,   num_next;
    logic [CS_W-1:0]   quo_reg,   quo_next;
    logic [DV_W-1:0]   rem_reg,   rem_next;
    logic [DV_W-1:0]   div_reg,   div_next;
    logic              last_reg,  last_next;
    logic              out_valid_reg, out_valid_next;
    bxds_pkg::result_t out_reg,   out_next;
    logic [DV_W:0]     rem_sh;
    logic              fit;

    // One restoring step.
    assign rem_sh = {rem_reg, num_reg[CS_W-1]};
    assign fit    = rem_sh >= {1'b0, div_reg};

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    num_next   = q_data[CS_W-1:0];
                    div_next   = q_data[CS_W +: DV_W];
                    last_next  = q_data[CS_W+DV_W];
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                num_next = {num_reg[CS_W-2:0], 1'b0};
                quo_next = {quo_reg[CS_W-2:0], fit};
                rem_next = fit ? DV_W'(rem_sh - {1'b0, div_reg}) : DV_W'(rem_sh);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CS_W-1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // The mean never exceeds the pixel range.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next   = 1'b1;
                    out_next.mean    = quo_reg[bxds_pkg::PIX_W-1:0];
                    out_next.row_end = last_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/box_average_downscaler_unit.sv =====
// ----------------------------------------------------------------------------
// box_average_downscaler_unit: top level of the box average downscaler
// Path: a finished tile's sum passes the column-sum update stage, the queue,
// the serial divider and its output register before its result leaves.
// Throughput: one pixel per cycle; each result occupies the serial divider
// until its quotient is done, and pixels stall once the
// four-entry queue is full. A register write blocks input for one cycle.
// Reset: synchronous, active low; a clearing pass over every line store entry
// follows reset and each tag wrap at a frame start, and blocks input meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_downscaler_unit #(
    parameter int MAX_WIDTH = bxds_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RATIO = bxds_pkg::MAX_RATIO_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration
    input  wire logic                               cfg_we,
    input  wire logic [bxds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bxds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Pixel input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // [7:0] pixel
    input  wire logic                               s_tuser,  // [0] frame_start
    // Result output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,  // [7:0] mean_pixel
    output logic                                    m_tlast   // row_end
);

    localparam int WC_W  = $clog2(MAX_WIDTH+1);
    localparam int RC_W  = $clog2(MAX_RATIO+1);
    localparam int DV_W  = $clog2(MAX_RATIO*MAX_RATIO+1);
    localparam int CS_W  = $clog2(MAX_RATIO*MAX_RATIO*255+1);
    localparam int ENT_W = CS_W + DV_W + 1;
    localparam int QD    = bxds_pkg::QUEUE_DEPTH;
    localparam int LV_W  = $clog2(QD+1);

    logic [bxds_pkg::IMAGE_WIDTH_W-1:0] iw_reg;
    logic [bxds_pkg::BLOCK_W-1:0]       bw_reg;
    logic [bxds_pkg::BLOCK_W-1:0]       bh_reg;
    logic [DV_W-1:0]                    div_reg;
    logic                               recalc_reg;
    logic [WC_W-1:0]                    w_clamp;
    logic [RC_W-1:0]                    bw_clamp;
    logic [RC_W-1:0]                    bh_clamp;

    logic                               q_push;
    logic [ENT_W-1:0]                   q_in;
    logic                               q_pop;
    logic                               q_valid;
    logic [ENT_W-1:0]                   q_head;
    logic [LV_W-1:0]                    q_level;
    bxds_pkg::front_status_t            front_status;
    bxds_pkg::result_t                  result;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg <= bxds_pkg::IMAGE_WIDTH_RST;
            bw_reg <= bxds_pkg::BLOCK_W_RST;
            bh_reg <= bxds_pkg::BLOCK_H_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bxds_pkg::REG_IMAGE_WIDTH: iw_reg <= cfg_wdata;
                bxds_pkg::REG_BLOCK_W:     bw_reg <= cfg_wdata[bxds_pkg::BLOCK_W-1:0];
                bxds_pkg::REG_BLOCK_H:     bh_reg <= cfg_wdata[bxds_pkg::BLOCK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Registers outside their range act as the nearest limit.
    always_comb begin
        if (iw_reg == '0) begin
            w_clamp = WC_W'(1);
        end else if (32'(iw_reg) > MAX_WIDTH) begin
            w_clamp = WC_W'(MAX_WIDTH);
        end else begin
            w_clamp = WC_W'(iw_reg);
        end
        if (bw_reg == '0) begin
            bw_clamp = RC_W'(1);
        end else if (32'(bw_reg) > MAX_RATIO) begin
            bw_clamp = RC_W'(MAX_RATIO);
        end else begin
            bw_clamp = RC_W'(bw_reg);
        end
        if (bh_reg == '0) begin
            bh_clamp = RC_W'(1);
        end else if (32'(bh_reg) > MAX_RATIO) begin
            bh_clamp = RC_W'(MAX_RATIO);
        end else begin
            bh_clamp = RC_W'(bh_reg);
        end
    end

    // Tile area and the one-cycle settle after a write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recalc_reg <= 1'b0;
        end else begin
            recalc_reg <= cfg_we;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= DV_W'(bw_clamp * bh_clamp);
    end

    bxds_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RATIO (MAX_RATIO),
        .QDEPTH    (QD)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_pixel       (s_tdata),
        .s_frame_start (s_tuser),
        .cfg_w         (w_clamp),
        .cfg_bw        (bw_clamp),
        .cfg_bh        (bh_clamp),
        .cfg_div       (div_reg),
        .cfg_recalc    (recalc_reg),
        .q_level       (q_level),
        .q_push        (q_push),
        .q_data        (q_in),
        .status        (front_status)
    );

    bxds_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QD)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_data (q_head),
        .level     (q_level)
    );

    bxds_divider #(
        .MAX_RATIO (MAX_RATIO)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = result.mean;
    assign m_tlast = result.row_end;

    // No pixel is taken while the line store is being cleared.
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        front_status.clearing |-> !s_tready)
        else $error("pixel accepted during clearing pass");

    // The queue always has room for a finished tile.
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        front_status.pushing |-> (q_level < LV_W'(QD)))
        else $error("finished tile pushed into a full queue");

    // The fill count never passes the queue depth.
    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= LV_W'(QD))
        else $error("queue level beyond depth");

    // Input pauses for a cycle after a register write.
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("pixel accepted before configuration settled");

endmodule

`default_nettype wire
